/* design/mi4_pkg.sv */
// Shared constants, widths, control structs and operand tables for the 4x4 inverse.
// Used by mi4_mac, mi4_div and matrix_inverse_4x4_core; depends on nothing else.
package mi4_pkg;

    // Fixed-point format and derived shift of the numerator
    localparam int FRAC_BITS = 16;
    localparam int SHIFT     = 2 * FRAC_BITS;

    // Element and multiplier limb widths
    localparam int W_EL   = 32;
    localparam int W_LIMB = 32;
    localparam int N_LIMB = 4;
    localparam int W_A    = W_LIMB * N_LIMB;
    localparam int W_PROD = W_LIMB + 1 + W_EL;

    // Exact widths of the 2x2 minors, 3x3 cofactors and determinant
    localparam int W_MIN = 2 * W_EL + 2;
    localparam int W_COF = W_MIN + W_EL + 2;
    localparam int W_ACC = W_COF + W_EL + 4;

    // Divider widths
    localparam int W_NUM    = W_COF + SHIFT;
    localparam int W_DEN_SH = W_ACC + W_EL;
    localparam int W_CMP    = (W_NUM > W_DEN_SH) ? W_NUM : W_DEN_SH;
    localparam int W_REM    = W_ACC + 1;

    localparam int N_EL  = 16;
    localparam int N_MIN = 12;
    localparam int N_ADJ = 16;

    typedef logic [3:0] t_idx;
    typedef logic [1:0] t_limb;

    // Command word from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic  start;
        logic  clr;
        logic  neg;
        t_limb top;
    } t_mac_ctl;

    // 2x2 minor m: el[a]*el[b] - el[c]*el[d], packed as {a, b, c, d}.
    // Minors 0..5 pair rows 0 and 1, minors 6..11 pair rows 2 and 3.
    function automatic logic [15:0] minor_terms(input t_idx m);
        logic [15:0] r;
        case (m)
            4'd0:    r = 16'h0541;
            4'd1:    r = 16'h0642;
            4'd2:    r = 16'h0743;
            4'd3:    r = 16'h1652;
            4'd4:    r = 16'h1753;
            4'd5:    r = 16'h2763;
            4'd6:    r = 16'h8DC9;
            4'd7:    r = 16'h8ECA;
            4'd8:    r = 16'h8FCB;
            4'd9:    r = 16'h9EDA;
            4'd10:   r = 16'h9FDB;
            4'd11:   r = 16'hAFEB;
            default: r = 16'h0000;
        endcase
        return r;
    endfunction

    // Adjugate entry k (row-major): three terms element x minor,
    // packed as {el0, mi0, el1, mi1, el2, mi2}; signs alternate by parity.
    function automatic logic [23:0] adj_terms(input t_idx k);
        logic [23:0] r;
        case (k)
            4'd0:    r = 24'h5B6A79;
            4'd1:    r = 24'h1B2A39;
            4'd2:    r = 24'hD5E4F3;
            4'd3:    r = 24'h95A4B3;
            4'd4:    r = 24'h4B6877;
            4'd5:    r = 24'h0B2837;
            4'd6:    r = 24'hC5E2F1;
            4'd7:    r = 24'h85A2B1;
            4'd8:    r = 24'h4A5876;
            4'd9:    r = 24'h0A1836;
            4'd10:   r = 24'hC4D2F0;
            4'd11:   r = 24'h8492B0;
            4'd12:   r = 24'h495766;
            4'd13:   r = 24'h091726;
            4'd14:   r = 24'hC3D1E0;
            default: r = 24'h8391A0;
        endcase
        return r;
    endfunction

endpackage

/* design/mi4_mac.sv */
// Limb-serial multiply-accumulate unit: wide signed operand times a 32-bit element.
// Depends on mi4_pkg for widths and the t_mac_ctl command struct.
module mi4_mac (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mi4_pkg::t_mac_ctl               i_ctl,
    input  logic [mi4_pkg::W_A-1:0]         i_a,
    input  logic signed [mi4_pkg::W_EL-1:0] i_b,
    output logic                            o_done,
    output logic signed [mi4_pkg::W_ACC-1:0] o_acc
);

    logic [mi4_pkg::W_A-1:0]            r_a;
    logic signed [mi4_pkg::W_EL-1:0]    r_b;
    mi4_pkg::t_limb                     r_top;
    mi4_pkg::t_limb                     r_limb;
    mi4_pkg::t_limb                     r_pshift;
    logic                               r_neg;
    logic                               r_run;
    logic                               r_pvalid;
    logic                               r_plast;
    logic                               r_done;
    logic signed [mi4_pkg::W_PROD-1:0]  r_prod;
    logic signed [mi4_pkg::W_ACC-1:0]   r_acc;

    logic [mi4_pkg::W_LIMB-1:0]         limb;
    logic                               ext;
    logic signed [mi4_pkg::W_LIMB:0]    limb_s;
    logic signed [mi4_pkg::W_ACC-1:0]   term;

    // Pick the current limb; only the top limb carries the sign
    always_comb begin
        limb   = r_a[r_limb*mi4_pkg::W_LIMB +: mi4_pkg::W_LIMB];
        ext    = (r_limb == r_top) ? limb[mi4_pkg::W_LIMB-1] : 1'b0;
        limb_s = {ext, limb};
        term   = mi4_pkg::W_ACC'(r_prod) <<< (mi4_pkg::W_LIMB * r_pshift);
    end

    // Sequence limbs and flag the final accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run    <= 1'b0;
            r_pvalid <= 1'b0;
            r_done   <= 1'b0;
            r_limb   <= '0;
        end else begin
            r_done   <= r_pvalid && r_plast;
            r_pvalid <= r_run;
            if (r_run) begin
                r_limb <= r_limb + 2'd1;
                if (r_limb == r_top) begin
                    r_run <= 1'b0;
                end
            end
            if (i_ctl.start) begin
                r_run  <= 1'b1;
                r_limb <= '0;
            end
        end
    end

    // Multiply one limb, then shift and accumulate the registered product
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_top <= i_ctl.top;
            r_neg <= i_ctl.neg;
        end
        if (r_run) begin
            r_prod   <= mi4_pkg::W_PROD'(limb_s) * mi4_pkg::W_PROD'(r_b);
            r_pshift <= r_limb;
            r_plast  <= (r_limb == r_top);
        end
        if (i_ctl.start && i_ctl.clr) begin
            r_acc <= '0;
        end else if (r_pvalid) begin
            r_acc <= r_neg ? (r_acc - term) : (r_acc + term);
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

endmodule

/* design/mi4_div.sv */
// Restoring divider: (num * 2^SHIFT) / den toward zero, saturated to 32 bits.
// Depends on mi4_pkg for operand widths and the fraction shift.
module mi4_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic signed [mi4_pkg::W_COF-1:0] i_num,
    input  logic signed [mi4_pkg::W_ACC-1:0] i_den,
    output logic                             o_done,
    output logic [mi4_pkg::W_EL-1:0]         o_value,
    output logic                             o_clip
);

    typedef enum logic [2:0] {
        D_IDLE,
        D_CHK,
        D_ITER,
        D_FIN
    } t_dstate;

    t_dstate                        r_st;
    logic [mi4_pkg::W_COF-1:0]      r_n;
    logic [mi4_pkg::W_ACC-1:0]      r_d;
    logic                           r_neg;
    logic                           r_clip;
    logic [mi4_pkg::W_REM-1:0]      r_rem;
    logic [mi4_pkg::W_EL-1:0]       r_low;
    logic [mi4_pkg::W_EL-1:0]       r_q;
    logic [4:0]                     r_cnt;
    logic [mi4_pkg::W_EL-1:0]       r_value;
    logic                           r_vclip;
    logic                           r_done;

    logic [mi4_pkg::W_CMP-1:0]      nsh;
    logic [mi4_pkg::W_CMP-1:0]      dsh;
    logic [mi4_pkg::W_REM-1:0]      rem2;
    logic [mi4_pkg::W_REM-1:0]      dext;
    logic                           ge;
    logic [mi4_pkg::W_EL-1:0]       limit;
    logic                           over;

    // Shifted operands, one restoring step and the saturation limit
    always_comb begin
        nsh   = mi4_pkg::W_CMP'(r_n) << mi4_pkg::SHIFT;
        dsh   = mi4_pkg::W_CMP'(r_d) << mi4_pkg::W_EL;
        dext  = mi4_pkg::W_REM'(r_d);
        rem2  = {r_rem[mi4_pkg::W_REM-2:0], r_low[mi4_pkg::W_EL-1]};
        ge    = (rem2 >= dext);
        limit = r_neg ? {1'b1, {(mi4_pkg::W_EL-1){1'b0}}}
                      : {1'b0, {(mi4_pkg::W_EL-1){1'b1}}};
        over  = r_clip || (r_q > limit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= D_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_st)
                // Take magnitudes and the result sign
                D_IDLE: begin
                    if (i_start) begin
                        r_n   <= i_num[mi4_pkg::W_COF-1] ? mi4_pkg::W_COF'(-i_num)
                                                         : mi4_pkg::W_COF'(i_num);
                        r_d   <= i_den[mi4_pkg::W_ACC-1] ? mi4_pkg::W_ACC'(-i_den)
                                                         : mi4_pkg::W_ACC'(i_den);
                        r_neg <= i_num[mi4_pkg::W_COF-1] ^ i_den[mi4_pkg::W_ACC-1];
                        r_st  <= D_CHK;
                    end
                end
                // Quotient of 2^32 or more always saturates; else seed remainder
                D_CHK: begin
                    r_clip <= (nsh >= dsh);
                    r_rem  <= mi4_pkg::W_REM'(nsh >> mi4_pkg::W_EL);
                    r_low  <= nsh[mi4_pkg::W_EL-1:0];
                    r_cnt  <= '0;
                    r_st   <= D_ITER;
                end
                // One quotient bit per cycle
                D_ITER: begin
                    r_rem <= ge ? (rem2 - dext) : rem2;
                    r_q   <= {r_q[mi4_pkg::W_EL-2:0], ge};
                    r_low <= r_low << 1;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_st <= D_FIN;
                    end
                end
                // Apply sign and saturation
                D_FIN: begin
                    r_value <= over ? limit : (r_neg ? (32'd0 - r_q) : r_q);
                    r_vclip <= over;
                    r_done  <= 1'b1;
                    r_st    <= D_IDLE;
                end
                default: r_st <= D_IDLE;
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_value = r_value;
    assign o_clip  = r_vclip;

endmodule

/* design/matrix_inverse_4x4_core.sv */
// 4x4 fixed-point matrix inverse core (cofactor / adjugate method).
// Depends on mi4_pkg, mi4_mac (shared multiply-accumulate) and mi4_div (divider).
//
// Load sixteen signed Q16.16 words in row-major order; the block stalls its input
// from the sixteenth word until the last result word is handed to the output
// register. It then forms twelve 2x2 minors, the sixteen adjugate entries and the
// exact determinant with one shared 33x32 multiplier that walks the wide operand
// 32 bits at a time, and divides each adjugate entry by the determinant in a
// bit-serial divider. A zero determinant yields one word with singular and last set.
module matrix_inverse_4x4_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [mi4_pkg::W_EL-1:0]   i_element,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [mi4_pkg::W_EL-1:0]   o_value,
    output logic                              o_singular,
    output logic                              o_clipped,
    output logic                              o_last
);

    typedef enum logic [3:0] {
        S_LOAD,
        S_FETCH_A,
        S_FETCH_B,
        S_MWAIT,
        S_ZCHK,
        S_DSTART,
        S_DWAIT,
        S_PUSH,
        S_SING
    } t_state;

    typedef enum logic [1:0] {
        PH_MIN,
        PH_ADJ,
        PH_DET
    } t_phase;

    t_state                              r_st;
    t_phase                              r_ph;
    mi4_pkg::t_idx                       r_cnt;
    mi4_pkg::t_idx                       r_grp;
    logic [1:0]                          r_term;
    logic [mi4_pkg::W_A-1:0]             r_opa;
    logic                                r_ovalid;
    logic signed [mi4_pkg::W_EL-1:0]     r_value;
    logic                                r_sing;
    logic                                r_clip;
    logic                                r_last;

    logic signed [mi4_pkg::W_EL-1:0]     r_mat [mi4_pkg::N_EL];
    logic signed [mi4_pkg::W_MIN-1:0]    r_min [mi4_pkg::N_MIN];
    logic signed [mi4_pkg::W_COF-1:0]    r_adj [mi4_pkg::N_ADJ];
    logic signed [mi4_pkg::W_ACC-1:0]    r_det;

    logic [15:0]                         mt;
    logic [23:0]                         at;
    mi4_pkg::t_idx                       adj_el;
    mi4_pkg::t_idx                       adj_mi;
    mi4_pkg::t_idx                       a_el;
    mi4_pkg::t_idx                       b_el;
    mi4_pkg::t_idx                       el_rd;
    mi4_pkg::t_idx                       adj_rd;
    logic                                neg;
    mi4_pkg::t_limb                      top;
    logic                                last_term;
    logic [mi4_pkg::W_A-1:0]             a_ext;
    logic                                accept;
    logic                                out_free;
    logic                                out_load;

    mi4_pkg::t_mac_ctl                   mac_ctl;
    logic                                mac_done;
    logic signed [mi4_pkg::W_ACC-1:0]    mac_acc;
    logic                                div_start;
    logic                                div_done;
    logic [mi4_pkg::W_EL-1:0]            div_value;
    logic                                div_clip;

    // Decode the current multiply-accumulate term from the operand tables
    always_comb begin
        mt = mi4_pkg::minor_terms(r_grp);
        at = mi4_pkg::adj_terms(r_grp);
        case (r_term)
            2'd0:    begin adj_el = at[23:20]; adj_mi = at[19:16]; end
            2'd1:    begin adj_el = at[15:12]; adj_mi = at[11:8];  end
            default: begin adj_el = at[7:4];   adj_mi = at[3:0];   end
        endcase
        case (r_ph)
            PH_MIN: begin
                a_el      = (r_term == 2'd0) ? mt[15:12] : mt[7:4];
                b_el      = (r_term == 2'd0) ? mt[11:8]  : mt[3:0];
                neg       = r_term[0];
                top       = 2'd0;
                last_term = (r_term == 2'd1);
            end
            PH_ADJ: begin
                a_el      = adj_el;
                b_el      = adj_el;
                neg       = (r_grp[2] ^ r_grp[0]) ^ (r_term == 2'd1);
                top       = 2'd2;
                last_term = (r_term == 2'd2);
            end
            default: begin
                a_el      = {2'b00, r_term};
                b_el      = {2'b00, r_term};
                neg       = 1'b0;
                top       = 2'd3;
                last_term = (r_term == 2'd3);
            end
        endcase
        el_rd  = (r_st == S_FETCH_A) ? a_el : b_el;
        adj_rd = (r_st == S_DSTART) ? r_grp : {r_term, 2'b00};
        case (r_ph)
            PH_MIN:  a_ext = mi4_pkg::W_A'(r_mat[el_rd]);
            PH_ADJ:  a_ext = mi4_pkg::W_A'(r_min[adj_mi]);
            default: a_ext = mi4_pkg::W_A'(r_adj[adj_rd]);
        endcase
    end

    assign accept    = i_valid && (r_st == S_LOAD);
    assign out_free  = !r_ovalid || !i_stall;
    assign out_load  = out_free && ((r_st == S_PUSH) || (r_st == S_SING));
    assign div_start = (r_st == S_DSTART);

    always_comb begin
        mac_ctl.start = (r_st == S_FETCH_B);
        mac_ctl.clr   = (r_term == 2'd0);
        mac_ctl.neg   = neg;
        mac_ctl.top   = top;
    end

    mi4_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_a     (r_opa),
        .i_b     (r_mat[el_rd]),
        .o_done  (mac_done),
        .o_acc   (mac_acc)
    );

    mi4_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_adj[adj_rd]),
        .i_den   (r_det),
        .o_done  (div_done),
        .o_value (div_value),
        .o_clip  (div_clip)
    );

    // Store loaded words and finished minors, adjugate entries and determinant
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mat[r_cnt] <= i_element;
        end
        if (r_st == S_FETCH_A) begin
            r_opa <= a_ext;
        end
        if ((r_st == S_MWAIT) && mac_done && last_term) begin
            case (r_ph)
                PH_MIN:  r_min[r_grp] <= mac_acc[mi4_pkg::W_MIN-1:0];
                PH_ADJ:  r_adj[r_grp] <= mac_acc[mi4_pkg::W_COF-1:0];
                default: r_det        <= mac_acc;
            endcase
        end
    end

    // Sequencer and output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_LOAD;
            r_ph     <= PH_MIN;
            r_cnt    <= '0;
            r_grp    <= '0;
            r_term   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // Load a new word when the register is free, else drop a taken one
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_st)
                S_LOAD: begin
                    if (i_valid) begin
                        r_cnt <= r_cnt + 4'd1;
                        if (r_cnt == 4'd15) begin
                            r_st   <= S_FETCH_A;
                            r_ph   <= PH_MIN;
                            r_grp  <= '0;
                            r_term <= '0;
                        end
                    end
                end
                S_FETCH_A: r_st <= S_FETCH_B;
                S_FETCH_B: r_st <= S_MWAIT;
                S_MWAIT: begin
                    if (mac_done) begin
                        r_st <= (last_term && (r_ph == PH_DET)) ? S_ZCHK : S_FETCH_A;
                        if (last_term) begin
                            r_term <= '0;
                            case (r_ph)
                                PH_MIN: begin
                                    if (r_grp == 4'd11) begin
                                        r_ph  <= PH_ADJ;
                                        r_grp <= '0;
                                    end else begin
                                        r_grp <= r_grp + 4'd1;
                                    end
                                end
                                PH_ADJ: begin
                                    r_grp <= r_grp + 4'd1;
                                    if (r_grp == 4'd15) begin
                                        r_ph <= PH_DET;
                                    end
                                end
                                default: r_grp <= '0;
                            endcase
                        end else begin
                            r_term <= r_term + 2'd1;
                        end
                    end
                end
                S_ZCHK: begin
                    r_grp <= '0;
                    r_st  <= (r_det == '0) ? S_SING : S_DSTART;
                end
                S_DSTART: r_st <= S_DWAIT;
                S_DWAIT: begin
                    if (div_done) begin
                        r_st <= S_PUSH;
                    end
                end
                // Hand one inverse word to the output register
                S_PUSH: begin
                    if (out_free) begin
                        r_value  <= div_value;
                        r_sing   <= 1'b0;
                        r_clip   <= div_clip;
                        r_last   <= (r_grp == 4'd15);
                        r_grp    <= r_grp + 4'd1;
                        r_st     <= (r_grp == 4'd15) ? S_LOAD : S_DSTART;
                    end
                end
                S_SING: begin
                    if (out_free) begin
                        r_value  <= '0;
                        r_sing   <= 1'b1;
                        r_clip   <= 1'b0;
                        r_last   <= 1'b1;
                        r_st     <= S_LOAD;
                    end
                end
                default: r_st <= S_LOAD;
            endcase
        end
    end

    assign o_stall    = (r_st != S_LOAD);
    assign o_valid    = r_ovalid;
    assign o_value    = r_value;
    assign o_singular = r_sing;
    assign o_clipped  = r_clip;
    assign o_last     = r_last;

`ifndef SYNTHESIS
    // A singular word is the only word of its matrix and carries zero
    a_sing_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_sing) |-> (r_last && !r_clip && (r_value == '0)))
        else $error("singular word without last or with nonzero value");

    // Division never starts on a zero determinant
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> (r_det != '0))
        else $error("divider started with zero determinant");

    // Accumulator completion only arrives while the sequencer waits for it
    a_mac_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_done |-> (r_st == S_MWAIT))
        else $error("multiply-accumulate done outside wait state");
`endif

endmodule

/* tb/sv/matrix_inverse_4x4_core_chk.sv */
// Checker for the 4x4 matrix inverse core: watches both channels, predicts each inverse.
// Depends on mi4_pkg for widths; instantiated by matrix_inverse_4x4_core_tb.
module matrix_inverse_4x4_core_chk (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic                            i_stall_in,
    input  logic signed [mi4_pkg::W_EL-1:0] i_element,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic signed [mi4_pkg::W_EL-1:0] i_value,
    input  logic                            i_singular,
    input  logic                            i_clipped,
    input  logic                            i_last,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_words_seen,
    output int                              o_singular_seen,
    output int                              o_clipped_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [31:0] value;
        logic               singular;
        logic               clipped;
        logic               last;
    } t_inv_word;

    logic signed [31:0] mat_words[16];
    int                 fill_count;
    t_inv_word          inverse_q[$];

    // 3x3 minor, signed, dropping row i and column j
    function automatic logic signed [255:0] cof3(int i, int j);
        int rs[3], cs[3], n, k;
        logic signed [255:0] e[3][3];
        logic signed [255:0] m;
        n = 0;
        for (k = 0; k < 4; k++) if (k != i) begin rs[n] = k; n++; end
        n = 0;
        for (k = 0; k < 4; k++) if (k != j) begin cs[n] = k; n++; end
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                e[r][c] = 256'(mat_words[rs[r] * 4 + cs[c]]);
        m = e[0][0] * (e[1][1] * e[2][2] - e[1][2] * e[2][1])
          - e[0][1] * (e[1][0] * e[2][2] - e[1][2] * e[2][0])
          + e[0][2] * (e[1][0] * e[2][1] - e[1][1] * e[2][0]);
        return ((i + j) % 2) ? -m : m;
    endfunction

    // Compute the inverse of the loaded matrix and queue its words
    task automatic predict_inverse();
        logic signed [255:0] cof[16];
        logic signed [255:0] det, num, q;
        t_inv_word w;
        det = 0;
        for (int k = 0; k < 16; k++) cof[k] = cof3(k / 4, k % 4);
        for (int j = 0; j < 4; j++) det += cof[j] * 256'(mat_words[j]);
        if (det == 0) begin
            w = '{value: 0, singular: 1'b1, clipped: 1'b0, last: 1'b1};
            inverse_q.push_back(w);
            return;
        end
        for (int k = 0; k < 16; k++) begin
            num = cof[(k % 4) * 4 + k / 4] <<< (2 * mi4_pkg::FRAC_BITS);
            q = num / det;  // truncates toward zero
            w.singular = 1'b0;
            w.last = (k == 15);
            if (q > 256'sh7FFFFFFF) begin
                w.value = 32'sh7FFFFFFF; w.clipped = 1'b1;
            end else if (q < -256'sh80000000) begin
                w.value = 32'sh80000000; w.clipped = 1'b1;
            end else begin
                w.value = q[31:0]; w.clipped = 1'b0;
            end
            inverse_q.push_back(w);
        end
    endtask

    // Track input words and compare output words
    always @(posedge i_clk) begin
        t_inv_word exp_w;
        if (!i_rst_n) begin
            fill_count <= 0;
            o_fail_count = 0;
            o_words_seen = 0;
            o_singular_seen = 0;
            o_clipped_seen = 0;
            o_pending = inverse_q.size();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                o_words_seen++;
                if (i_singular) o_singular_seen++;
                if (i_clipped) o_clipped_seen++;
                if (inverse_q.size() == 0) begin
                    $display("%0t: unexpected word value=%h sing=%b clip=%b last=%b",
                             $time, i_value, i_singular, i_clipped, i_last);
                    o_fail_count++;
                end else begin
                    exp_w = inverse_q.pop_front();
                    if (exp_w.value !== i_value || exp_w.singular !== i_singular ||
                        exp_w.clipped !== i_clipped || exp_w.last !== i_last) begin
                        $display("%0t: mismatch expected value=%h sing=%b clip=%b last=%b",
                                 $time, exp_w.value, exp_w.singular, exp_w.clipped,
                                 exp_w.last);
                        $display("%0t:          actual   value=%h sing=%b clip=%b last=%b",
                                 $time, i_value, i_singular, i_clipped, i_last);
                        o_fail_count++;
                    end
                end
            end
            if (i_valid && !i_stall_in) begin
                mat_words[fill_count] = i_element;
                if (fill_count == 15) begin
                    predict_inverse();
                    fill_count <= 0;
                end else begin
                    fill_count <= fill_count + 1;
                end
            end
            o_pending = inverse_q.size();
        end
    end
endmodule

/* tb/sv/matrix_inverse_4x4_core_tb.sv */
// Top of the 4x4 matrix inverse testbench: clock, reset, matrix stimulus and verdict.
// Depends on mi4_pkg, matrix_inverse_4x4_core and matrix_inverse_4x4_core_chk.
module matrix_inverse_4x4_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ONE = 1 << mi4_pkg::FRAC_BITS;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] in_element;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] out_value;
    logic               out_singular;
    logic               out_clipped;
    logic               out_last;
    int                 fail_count, pending, words_seen, sing_seen, clip_seen;
    int                 matrices_sent;

    matrix_inverse_4x4_core u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (in_valid),
        .o_stall    (in_stall),
        .i_element  (in_element),
        .o_valid    (out_valid),
        .i_stall    (out_stall),
        .o_value    (out_value),
        .o_singular (out_singular),
        .o_clipped  (out_clipped),
        .o_last     (out_last)
    );

    matrix_inverse_4x4_core_chk u_chk (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (in_valid),
        .i_stall_in     (in_stall),
        .i_element      (in_element),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_value        (out_value),
        .i_singular     (out_singular),
        .i_clipped      (out_clipped),
        .i_last         (out_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_words_seen   (words_seen),
        .o_singular_seen(sing_seen),
        .o_clipped_seen (clip_seen)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Stall the output at random, chosen anew each cycle: mostly free, sometimes held
    initial begin
        int mode;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            mode = $urandom_range(0, 99);
            if (mode < 60) out_stall <= 1'b0;
            else if (mode < 90) out_stall <= ($urandom_range(0, 2) == 0);
            else out_stall <= 1'b1;
        end
    end

    // Send one word and hold it until accepted; drop valid for a random gap now and then
    task automatic send_word(logic signed [31:0] w);
        if ($urandom_range(0, 5) == 0) begin
            in_valid   <= 1'b0;
            in_element <= $urandom;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid   <= 1'b1;
        in_element <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_matrix(logic signed [31:0] m[16]);
        for (int k = 0; k < 16; k++) send_word(m[k]);
        matrices_sent++;
    endtask

    // Random element of mixed magnitude so every bit gets exercised
    function automatic logic signed [31:0] rand_element();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return $signed($urandom_range(0, 4 * ONE)) - 2 * ONE;
            2:       return $signed($urandom_range(0, 511)) - 256;
            default: return $signed($urandom_range(0, 64 * ONE)) - 32 * ONE;
        endcase
    endfunction

    initial begin
        logic signed [31:0] m[16];
        in_valid = 1'b0;
        in_element = '0;
        rst_n = 1'b0;
        matrices_sent = 0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Identity
        for (int k = 0; k < 16; k++) m[k] = (k % 5 == 0) ? ONE : 0;
        send_matrix(m);
        // All zero: singular
        for (int k = 0; k < 16; k++) m[k] = 0;
        send_matrix(m);
        // Tiny diagonal: saturating positive and negative
        for (int k = 0; k < 16; k++) m[k] = (k % 5 == 0) ? ((k == 5) ? -1 : 1) : 0;
        send_matrix(m);
        // Extreme values on the diagonal, the rest zero
        for (int k = 0; k < 16; k++)
            m[k] = (k % 5 == 0) ? ((k < 8) ? 32'sh7FFFFFFF : 32'sh80000000) : 0;
        send_matrix(m);

        // Random matrices; some with duplicated rows to force singularity, some cut to their diagonal
        for (int n = 0; n < 6; n++) begin
            for (int k = 0; k < 16; k++) m[k] = rand_element();
            if ($urandom_range(0, 3) == 0)
                for (int c = 0; c < 4; c++) m[12 + c] = m[$urandom_range(0, 2) * 4 + c];
            else if ($urandom_range(0, 4) == 0)
                for (int k = 0; k < 16; k++) if (k % 5 != 0) m[k] = 0;
            send_matrix(m);
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (1200) @(posedge clk);
        $display("Covered %0d matrices (%0d words out, %0d singular, %0d clipped)",
                 matrices_sent, words_seen, sing_seen, clip_seen);
        if (fail_count == 0) begin
            $display("matrix_inverse_4x4_core_tb: PASS");
        end else begin
            $display("matrix_inverse_4x4_core_tb: FAIL");
        end
        $finish;
    end

    // Timeout
    initial begin
        #20ms;
        $display("matrix_inverse_4x4_core_tb: FAIL");
        $finish;
    end
endmodule

/* files.f */
design/mi4_pkg.sv
design/mi4_mac.sv
design/mi4_div.sv
design/matrix_inverse_4x4_core.sv
tb/sv/matrix_inverse_4x4_core_chk.sv
tb/sv/matrix_inverse_4x4_core_tb.sv
